### hdl/rls_pkg.sv
// ----------------------------------------------------------------------------
// rls_pkg - shared definitions for the region luma statistics core
// Register indexes, reset values, sequencer states and the luma function.
// ----------------------------------------------------------------------------
package rls_pkg;

    // Default limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int MAX_STEP_DEF   = 63;

    // Configuration port shape
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Register reset values
    localparam logic [11:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [10:0] RST_REGION_LEFT   = 11'd0;
    localparam logic [10:0] RST_REGION_TOP    = 11'd0;
    localparam logic [11:0] RST_REGION_RIGHT  = 12'd640;
    localparam logic [11:0] RST_REGION_BOTTOM = 12'd480;
    localparam logic [5:0]  RST_SAMPLE_STEP   = 6'd6;

    // Luma at or above this counts as saturated
    localparam logic [7:0] SAT_LUMA  = 8'd245;
    localparam logic [4:0] FIVE_MASK = 5'h1F;
    localparam logic [5:0] SIX_MASK  = 6'h3F;

    // Quotient bits produced by the divider (fractions reach 65536)
    localparam int QUO_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH   = 3'd0,
        CFG_REGION_LEFT   = 3'd1,
        CFG_REGION_TOP    = 3'd2,
        CFG_REGION_RIGHT  = 3'd3,
        CFG_REGION_BOTTOM = 3'd4,
        CFG_SAMPLE_STEP   = 3'd5
    } t_cfg_idx;

    // Frame-end sequencer
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MEAN = 5'b00010,
        S_FRAC = 5'b00100,
        S_TEX  = 5'b01000,
        S_POST = 5'b10000
    } t_state;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Approximate luma: (r8 + 2*g8 + b8) >> 2
    function automatic logic [7:0] pixel_luma(input logic [15:0] p);
        logic [9:0] hi;
        logic [9:0] gr;
        logic [9:0] lo;
        logic [9:0] sum;
        hi  = {2'b00, (p[15:11] & FIVE_MASK), 3'b000};
        gr  = {1'b0, (p[10:5] & SIX_MASK), 3'b000};
        lo  = {2'b00, (p[4:0] & FIVE_MASK), 3'b000};
        sum = hi + gr + lo;
        return sum[9:2];
    endfunction

endpackage

### hdl/rls_divider.sv
// ----------------------------------------------------------------------------
// rls_divider - shared restoring divider
// One quotient bit per cycle. The caller guarantees dividend >> QUO_W is
// below the divisor, so QUO_W steps give the whole quotient.
// ----------------------------------------------------------------------------
module rls_divider #(
    parameter int DVS_W = 23
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DVS_W+16-1:0]           i_dividend,
    input  logic [DVS_W-1:0]              i_divisor,
    output rls_pkg::t_div_stat            o_stat,
    output logic [rls_pkg::QUO_W-1:0]     o_quotient
);
    import rls_pkg::*;

    localparam int DVD_W = DVS_W + 16;
    localparam int CNT_W = $clog2(QUO_W);

    logic [DVS_W-1:0] r_rem;
    logic [QUO_W-1:0] r_lo;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   rem_sh;
    logic             q_bit;
    logic [DVS_W:0]   rem_sub;

    // One trial subtraction per cycle
    assign rem_sh  = {r_rem, r_lo[QUO_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DVS_W'(i_dividend[DVD_W-1:QUO_W]);
            r_lo  <= i_dividend[QUO_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_lo  <= {r_lo[QUO_W-2:0], q_bit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_lo;

endmodule

### hdl/region_luma_statistics_core.sv
// ----------------------------------------------------------------------------
// region_luma_statistics_core - sampled luma statistics over a frame region
// Accumulates luma sum, saturation and horizontal gradients per frame and
// reports mean, saturated fraction, texture and both counts after the frame's last pixel.
// ----------------------------------------------------------------------------
// A pixel's statistics update at the edge that accepts it.
// After the pixel flagged last, o_pixel_stall stays high while one shared
// bit-serial divider runs three divisions (mean, saturated fraction, texture),
// one quotient bit per cycle; then the result is moved into the output register
// and the frame counters clear. The output register holds the result until taken,
// while the next frame's pixels flow; a second frame end waits for that register
// to empty. The config port is always ready and is to be written only while no
// frame end is in progress.
module region_luma_statistics_core #(
    parameter int MAX_WIDTH  = rls_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rls_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_STEP   = rls_pkg::MAX_STEP_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Pixel input
    input  logic                           i_pixel_valid,
    output logic                           o_pixel_stall,
    input  logic [15:0]                    i_pixel,
    input  logic                           i_last_pixel,
    // Result output
    output logic                           o_result_valid,
    input  logic                           i_result_stall,
    output logic [15:0]                    o_mean_luma,
    output logic [16:0]                    o_saturated_fraction,
    output logic [15:0]                    o_texture,
    output logic [22:0]                    o_sample_total,
    output logic [22:0]                    o_gradient_total,
    // Configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rls_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rls_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int PH_W   = (MAX_STEP > 1) ? $clog2(MAX_STEP) : 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W  = CNT_W + 8;
    localparam int CMP_A  = (COL_W + 1 > ROW_W) ? COL_W + 1 : ROW_W;
    localparam int CMP_W  = (CMP_A > CFG_DATA_W) ? CMP_A : CFG_DATA_W;
    localparam int DVD_W  = CNT_W + 16;

    // Configuration registers
    logic [11:0]      r_frame_width;
    logic [10:0]      r_region_left;
    logic [10:0]      r_region_top;
    logic [11:0]      r_region_right;
    logic [11:0]      r_region_bottom;
    logic [5:0]       r_sample_step;

    // Frame state
    logic [COL_W-1:0] r_col,       n_col;
    logic [ROW_W-1:0] r_row,       n_row;
    logic [PH_W-1:0]  r_cph,       n_cph;
    logic [PH_W-1:0]  r_rph,       n_rph;
    logic [SUM_W-1:0] r_luma_sum,  n_luma_sum;
    logic [CNT_W-1:0] r_sat_cnt,   n_sat_cnt;
    logic [SUM_W-1:0] r_grad_sum,  n_grad_sum;
    logic [CNT_W-1:0] r_samples,   n_samples;
    logic [CNT_W-1:0] r_grads,     n_grads;
    logic [7:0]       r_prev_luma, n_prev_luma;
    logic             r_prev_valid, n_prev_valid;

    // Sequencer and results
    t_state           r_state, n_state;
    logic             r_start, n_start;
    logic [QUO_W-1:0] r_q_mean;
    logic [QUO_W-1:0] r_q_frac;
    logic             r_o_valid;
    logic [15:0]      r_o_mean;
    logic [16:0]      r_o_frac;
    logic [15:0]      r_o_tex;
    logic [22:0]      r_o_samples;
    logic [22:0]      r_o_grads;

    logic             pix_acc;
    logic             out_free;
    logic             post_load;
    logic             cfg_wr;

    logic [CMP_W-1:0] fw_e;
    logic [CMP_W-1:0] width_c;
    logic [CMP_W-1:0] st_e;
    logic [CMP_W-1:0] step_c;
    logic [CMP_W-1:0] rr_e;
    logic [CMP_W-1:0] right_c;
    logic [CMP_W-1:0] col_e;
    logic [CMP_W-1:0] row_e;
    logic             row_in;
    logic             col_ge_left;
    logic             col_in;
    logic             take;
    logic [7:0]       luma;
    logic [7:0]       diff;

    logic [DVD_W-1:0] div_dividend;
    logic [CNT_W-1:0] div_divisor;
    t_div_stat        div_stat;
    logic [QUO_W-1:0] div_quo;

    assign pix_acc   = i_pixel_valid && !o_pixel_stall;
    assign out_free  = !r_o_valid || !i_result_stall;
    assign post_load = (r_state == S_POST) && out_free;
    assign cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= RST_FRAME_WIDTH;
            r_region_left   <= RST_REGION_LEFT;
            r_region_top    <= RST_REGION_TOP;
            r_region_right  <= RST_REGION_RIGHT;
            r_region_bottom <= RST_REGION_BOTTOM;
            r_sample_step   <= RST_SAMPLE_STEP;
        end else if (cfg_wr) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                CFG_REGION_LEFT:   r_region_left   <= i_cfg_data[10:0];
                CFG_REGION_TOP:    r_region_top    <= i_cfg_data[10:0];
                CFG_REGION_RIGHT:  r_region_right  <= i_cfg_data;
                CFG_REGION_BOTTOM: r_region_bottom <= i_cfg_data;
                CFG_SAMPLE_STEP:   r_sample_step   <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // Clipped geometry
    always_comb begin
        fw_e    = CMP_W'(r_frame_width);
        width_c = (fw_e == '0) ? CMP_W'(1) :
                  (fw_e > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : fw_e;
        st_e    = CMP_W'(r_sample_step);
        step_c  = (st_e == '0) ? CMP_W'(1) :
                  (st_e > CMP_W'(MAX_STEP)) ? CMP_W'(MAX_STEP) : st_e;
        rr_e    = CMP_W'(r_region_right);
        right_c = (rr_e < width_c) ? rr_e : width_c;
        col_e   = CMP_W'(r_col);
        row_e   = CMP_W'(r_row);
    end

    // Sample decision and luma
    assign row_in      = (row_e < CMP_W'(MAX_HEIGHT)) && (row_e >= CMP_W'(r_region_top))
                         && (row_e < CMP_W'(r_region_bottom));
    assign col_ge_left = col_e >= CMP_W'(r_region_left);
    assign col_in      = col_ge_left && (col_e < right_c);
    assign take        = row_in && col_in && (r_rph == '0) && (r_cph == '0);
    assign luma        = pixel_luma(i_pixel);
    assign diff        = (luma >= r_prev_luma) ? (luma - r_prev_luma) : (r_prev_luma - luma);

    // Next frame state for an accepted pixel
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_cph        = r_cph;
        n_rph        = r_rph;
        n_luma_sum   = r_luma_sum;
        n_sat_cnt    = r_sat_cnt;
        n_grad_sum   = r_grad_sum;
        n_samples    = r_samples;
        n_grads      = r_grads;
        n_prev_luma  = r_prev_luma;
        n_prev_valid = r_prev_valid;
        if (col_ge_left) begin
            if (take) begin
                n_luma_sum = r_luma_sum + SUM_W'(luma);
                n_samples  = r_samples + CNT_W'(1);
                if (luma >= SAT_LUMA) begin
                    n_sat_cnt = r_sat_cnt + CNT_W'(1);
                end
                if (r_prev_valid) begin
                    n_grad_sum = r_grad_sum + SUM_W'(diff);
                    n_grads    = r_grads + CNT_W'(1);
                end
                n_prev_luma  = luma;
                n_prev_valid = 1'b1;
            end
            n_cph = (CMP_W'(r_cph) + CMP_W'(1) >= step_c) ? '0 : r_cph + PH_W'(1);
        end
        // End of row
        if (col_e + CMP_W'(1) >= width_c) begin
            n_col        = '0;
            n_cph        = '0;
            n_prev_valid = 1'b0;
            if (row_e >= CMP_W'(r_region_top)) begin
                n_rph = (CMP_W'(r_rph) + CMP_W'(1) >= step_c) ? '0 : r_rph + PH_W'(1);
            end
            if (row_e < CMP_W'(MAX_HEIGHT)) begin
                n_row = r_row + ROW_W'(1);
            end
        end else begin
            n_col = r_col + COL_W'(1);
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || post_load) begin
            r_col        <= '0;
            r_row        <= '0;
            r_cph        <= '0;
            r_rph        <= '0;
            r_luma_sum   <= '0;
            r_sat_cnt    <= '0;
            r_grad_sum   <= '0;
            r_samples    <= '0;
            r_grads      <= '0;
            r_prev_luma  <= '0;
            r_prev_valid <= 1'b0;
        end else if (pix_acc) begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_cph        <= n_cph;
            r_rph        <= n_rph;
            r_luma_sum   <= n_luma_sum;
            r_sat_cnt    <= n_sat_cnt;
            r_grad_sum   <= n_grad_sum;
            r_samples    <= n_samples;
            r_grads      <= n_grads;
            r_prev_luma  <= n_prev_luma;
            r_prev_valid <= n_prev_valid;
        end
    end

    // Frame-end sequencer
    always_comb begin
        n_state = r_state;
        n_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (pix_acc && i_last_pixel) begin
                    n_state = S_MEAN;
                    n_start = 1'b1;
                end
            end
            S_MEAN: begin
                if (div_stat.done) begin
                    n_state = S_FRAC;
                    n_start = 1'b1;
                end
            end
            S_FRAC: begin
                if (div_stat.done) begin
                    n_state = S_TEX;
                    n_start = 1'b1;
                end
            end
            S_TEX: begin
                if (div_stat.done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
        end
    end

    // Operand select for the shared divider
    always_comb begin
        case (r_state)
            S_FRAC: begin
                div_dividend = {r_sat_cnt, 16'd0};
                div_divisor  = r_samples;
            end
            S_TEX: begin
                div_dividend = {r_grad_sum, 8'd0};
                div_divisor  = r_grads;
            end
            default: begin
                div_dividend = {r_luma_sum, 8'd0};
                div_divisor  = r_samples;
            end
        endcase
    end

    rls_divider #(
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (div_quo)
    );

    // Capture quotients, zero where the count is zero
    always_ff @(posedge i_clk) begin
        if (div_stat.done && (r_state == S_MEAN)) begin
            r_q_mean <= (r_samples != '0) ? div_quo : '0;
        end
        if (div_stat.done && (r_state == S_FRAC)) begin
            r_q_frac <= (r_samples != '0) ? div_quo : '0;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (post_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_result_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (post_load) begin
            r_o_mean    <= r_q_mean[15:0];
            r_o_frac    <= r_q_frac;
            r_o_tex     <= (r_grads != '0) ? div_quo[15:0] : 16'd0;
            r_o_samples <= 23'(r_samples);
            r_o_grads   <= 23'(r_grads);
        end
    end

    assign o_pixel_stall        = (r_state != S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_result_valid       = r_o_valid;
    assign o_mean_luma          = r_o_mean;
    assign o_saturated_fraction = r_o_frac;
    assign o_texture            = r_o_tex;
    assign o_sample_total       = r_o_samples;
    assign o_gradient_total     = r_o_grads;

endmodule

### hdl/rls_checker.sv
// ----------------------------------------------------------------------------
// rls_checker - port-level checks for region_luma_statistics_core
// Watches the handshakes and result fields; bound to the top level below.
// ----------------------------------------------------------------------------
module rls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_pixel_valid,
    input logic        o_pixel_stall,
    input logic        i_last_pixel,
    input logic        o_result_valid,
    input logic        i_result_stall,
    input logic [15:0] o_mean_luma,
    input logic [16:0] o_saturated_fraction,
    input logic [15:0] o_texture,
    input logic [22:0] o_sample_total,
    input logic [22:0] o_gradient_total
);

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid right after reset");

    // Frame end blocks further pixels while the divisions run
    a_frame_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pixel_valid && !o_pixel_stall && i_last_pixel) |=> o_pixel_stall)
        else $error("pixel input open right after frame end");

    // Stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && i_result_stall) |=>
            (o_result_valid && $stable(o_mean_luma) && $stable(o_texture)
             && $stable(o_saturated_fraction) && $stable(o_sample_total)))
        else $error("stalled result changed");

    // Empty counts give zero ratios, fraction stays at or below one
    a_zero_samples: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_sample_total == 23'd0) |->
            (o_mean_luma == 16'd0 && o_saturated_fraction == 17'd0))
        else $error("nonzero ratio with no samples");

    a_zero_grads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |->
            ((o_gradient_total != 23'd0 || o_texture == 16'd0)
             && o_saturated_fraction <= 17'd65536))
        else $error("texture without gradients or fraction above one");

endmodule

bind region_luma_statistics_core rls_checker u_rls_checker (.*);

### dv/tb_region_luma_statistics_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_region_luma_statistics_core - self-checking bench for the luma stats core
// Streams RGB565 frames through the pixel channel and predicts each frame-end
// report (mean luma, saturated fraction, texture and counts) with a model kept
// inside the bench. Registers are rewritten between phases, sometimes with a
// frame still open. Both channels idle at random, apart from one quiet phase.
// ----------------------------------------------------------------------------
module tb_region_luma_statistics_core;
    import rls_pkg::*;

    localparam int IDLE_PCT         = 28;
    localparam int RANDOM_PIXELS    = 1600;
    // Drain time covering the three divisions plus the move into the output register
    localparam int DIV_DRAIN_CYCLES = 70;
    localparam int RUN_LIMIT_NS     = 5_000_000;
    // Index that maps to no register; the write must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd6;

    typedef struct packed {
        logic [15:0] avg_luma;
        logic [16:0] bright_share;
        logic [15:0] texture;
        logic [22:0] sample_total;
        logic [22:0] gradient_total;
    } t_frame_stats;

    typedef struct packed {
        logic [15:0] pixel;
        logic        is_last;
    } t_pixel_item;

    // DUT inputs, known from time zero
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_pixel_valid  = 1'b0;
    logic [15:0]           i_pixel        = '0;
    logic                  i_last_pixel   = 1'b0;
    logic                  i_result_stall = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    logic        o_pixel_stall;
    logic        o_result_valid;
    logic [15:0] o_mean_luma;
    logic [16:0] o_saturated_fraction;
    logic [15:0] o_texture;
    logic [22:0] o_sample_total;
    logic [22:0] o_gradient_total;
    logic        o_cfg_ready;

    region_luma_statistics_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_pixel_valid        (i_pixel_valid),
        .o_pixel_stall        (o_pixel_stall),
        .i_pixel              (i_pixel),
        .i_last_pixel         (i_last_pixel),
        .o_result_valid       (o_result_valid),
        .i_result_stall       (i_result_stall),
        .o_mean_luma          (o_mean_luma),
        .o_saturated_fraction (o_saturated_fraction),
        .o_texture            (o_texture),
        .o_sample_total       (o_sample_total),
        .o_gradient_total     (o_gradient_total),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Bench-side copy of the registers
    logic [11:0] cfg_width  = RST_FRAME_WIDTH;
    logic [10:0] cfg_left   = RST_REGION_LEFT;
    logic [10:0] cfg_top    = RST_REGION_TOP;
    logic [11:0] cfg_right  = RST_REGION_RIGHT;
    logic [11:0] cfg_bottom = RST_REGION_BOTTOM;
    logic [5:0]  cfg_pitch  = RST_SAMPLE_STEP;

    // Bench-side frame state
    logic [10:0] col_count    = '0;
    logic [11:0] row_count    = '0;
    logic [5:0]  col_phase    = '0;
    logic [5:0]  row_phase    = '0;
    logic [29:0] luma_sum     = '0;
    logic [22:0] sat_count    = '0;
    logic [29:0] grad_sum     = '0;
    logic [22:0] sample_count = '0;
    logic [22:0] grad_count   = '0;
    logic [7:0]  prev_luma    = '0;
    logic        prev_valid   = 1'b0;

    t_pixel_item  pixel_queue[$];
    t_frame_stats expected_stats[$];

    bit calm           = 1'b0;
    int mismatches     = 0;
    int pixels_taken   = 0;
    int frames_checked = 0;
    int cfg_writes     = 0;

    // Advance the frame model by one pixel; returns 1 with the report on frame end
    function automatic bit predict_frame_stats(input logic [15:0] px, input logic is_last,
                                               output t_frame_stats res);
        int unsigned width, pitch, right, luma, diff;
        longint unsigned num;
        bit row_in, col_in;
        width = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_width);
        pitch = (cfg_pitch == 0) ? 1 : ((cfg_pitch > MAX_STEP_DEF) ? MAX_STEP_DEF : cfg_pitch);
        right = (cfg_right < width) ? cfg_right : width;
        row_in = (row_count < MAX_HEIGHT_DEF) && (row_count >= cfg_top) &&
                 (row_count < cfg_bottom);
        col_in = (col_count >= cfg_left) && (col_count < right);
        res = '0;

        // Sampling and accumulation
        if (col_count >= cfg_left) begin
            if (row_in && col_in && row_phase == 0 && col_phase == 0) begin
                // (8r + 8g + 8b) >> 2 is twice the sum of the raw fields
                luma = 2 * (int'(px[15:11]) + int'(px[10:5]) + int'(px[4:0]));
                luma_sum     = luma_sum + 30'(luma);
                sample_count = sample_count + 23'd1;
                if (luma >= SAT_LUMA) sat_count = sat_count + 23'd1;
                if (prev_valid) begin
                    diff = (luma >= prev_luma) ? luma - prev_luma : prev_luma - luma;
                    grad_sum   = grad_sum + 30'(diff);
                    grad_count = grad_count + 23'd1;
                end
                prev_luma  = luma[7:0];
                prev_valid = 1'b1;
            end
            col_phase = (col_phase + 1 >= pitch) ? '0 : col_phase + 6'd1;
        end

        // Raster position
        if (col_count + 1 >= width) begin
            col_count  = '0;
            col_phase  = '0;
            prev_valid = 1'b0;
            if (row_count >= cfg_top)
                row_phase = (row_phase + 1 >= pitch) ? '0 : row_phase + 6'd1;
            if (row_count < MAX_HEIGHT_DEF) row_count = row_count + 12'd1;
        end else begin
            col_count = col_count + 11'd1;
        end

        if (!is_last) return 1'b0;

        // Frame-end report
        if (sample_count != 0) begin
            num = longint'(luma_sum) << 8;
            res.avg_luma = 16'(num / sample_count);
            num = longint'(sat_count) << 16;
            res.bright_share = 17'(num / sample_count);
        end
        if (grad_count != 0) begin
            num = longint'(grad_sum) << 8;
            res.texture = 16'(num / grad_count);
        end
        res.sample_total   = sample_count;
        res.gradient_total = grad_count;

        col_count    = '0;
        row_count    = '0;
        col_phase    = '0;
        row_phase    = '0;
        luma_sum     = '0;
        sat_count    = '0;
        grad_sum     = '0;
        sample_count = '0;
        grad_count   = '0;
        prev_luma    = '0;
        prev_valid   = 1'b0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Mostly uniform words, a quarter of them bright, some of those above the saturation level
    function automatic logic [15:0] random_pixel();
        if ($urandom_range(0, 3) == 0)
            return {5'($urandom_range(26, 31)), 6'($urandom_range(52, 63)),
                    5'($urandom_range(26, 31))};
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic void push_pixel(input logic [15:0] px, input logic is_last);
        t_pixel_item item;
        item.pixel   = px;
        item.is_last = is_last;
        pixel_queue.push_back(item);
    endfunction

    task automatic queue_pixels(input int count, input bit close_frame);
        for (int k = 0; k < count; k++)
            push_pixel(random_pixel(), close_frame && (k == count - 1));
    endtask

    // Pixel driver: predicts on every accepted item, then loads the next one
    always @(posedge i_clk) begin : pixel_driver
        t_frame_stats stats;
        t_pixel_item  item;
        if (i_rst_n) begin
            if (i_pixel_valid && !o_pixel_stall) begin
                pixels_taken++;
                if (predict_frame_stats(i_pixel, i_last_pixel, stats))
                    expected_stats.push_back(stats);
            end
            if (!i_pixel_valid || !o_pixel_stall) begin
                if (pixel_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    item = pixel_queue.pop_front();
                    i_pixel_valid <= 1'b1;
                    i_pixel       <= item.pixel;
                    i_last_pixel  <= item.is_last;
                end else begin
                    i_pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge i_clk) begin : result_monitor
        t_frame_stats want;
        if (i_rst_n) begin
            if (o_result_valid && !i_result_stall) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got mean %0d frac %0d tex %0d",
                             $time, o_mean_luma, o_saturated_fraction, o_texture);
                    mismatches++;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("average luma", want.avg_luma, o_mean_luma);
                    check_field("saturated_fraction", want.bright_share, o_saturated_fraction);
                    check_field("texture", want.texture, o_texture);
                    check_field("sample_total", want.sample_total, o_sample_total);
                    check_field("gradient_total", want.gradient_total, o_gradient_total);
                    frames_checked++;
                end
            end
            i_result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // One register write; the bench copy follows at the accepting edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:   cfg_width  = data;
            CFG_REGION_LEFT:   cfg_left   = data[10:0];
            CFG_REGION_TOP:    cfg_top    = data[10:0];
            CFG_REGION_RIGHT:  cfg_right  = data;
            CFG_REGION_BOTTOM: cfg_bottom = data;
            CFG_SAMPLE_STEP:   cfg_pitch  = data[5:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Left and top carry a random unused top bit
    task automatic set_config(input logic [11:0] w, input logic [10:0] l, input logic [10:0] t,
                              input logic [11:0] r, input logic [11:0] b, input logic [5:0] s);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_REGION_LEFT, {1'($urandom_range(0, 1)), l});
        write_reg(CFG_REGION_TOP, {1'($urandom_range(0, 1)), t});
        write_reg(CFG_REGION_RIGHT, r);
        write_reg(CFG_REGION_BOTTOM, b);
        write_reg(CFG_SAMPLE_STEP, {6'd0, s});
    endtask

    task automatic randomize_config();
        logic [11:0] w, r, b;
        logic [10:0] l, t;
        logic [5:0]  s;
        case ($urandom_range(0, 9))
            0:       w = 12'd0;
            1:       w = 12'd1;
            2:       w = 12'hFFF;
            default: w = 12'($urandom_range(2, 12));
        endcase
        l = ($urandom_range(0, 9) == 0) ? 11'h7FF : 11'($urandom_range(0, 6));
        t = ($urandom_range(0, 9) == 0) ? 11'h7FF : 11'($urandom_range(0, 4));
        r = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 14));
        b = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 10));
        case ($urandom_range(0, 9))
            0:       s = 6'd0;
            1:       s = 6'd63;
            default: s = 6'($urandom_range(1, 3));
        endcase
        set_config(w, l, t, r, b, s);
    endtask

    // Sender holds off until every report is in and the divider has settled;
    // checked mid-cycle so the driver's updates at the edge are already visible
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_pixel_valid || expected_stats.size() != 0);
        repeat (DIV_DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int random_pixels;
        int phase;
        int frame_len;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small full rectangle, pitch 1: field extremes and the saturation boundary
        set_config(12'd4, 11'd0, 11'd0, 12'd4, 12'd4, 6'd1);
        write_reg(CFG_UNUSED_IDX, 12'hFFF);
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'hF800, 1'b0);
        push_pixel(16'h07E0, 1'b0);
        push_pixel(16'h001F, 1'b0);
        push_pixel(16'hFFBF, 1'b0);
        push_pixel(16'hFF9F, 1'b0);
        push_pixel(16'hFFFF, 1'b1);
        wait_drained();

        // Empty rectangle: no samples, all ratios zero
        set_config(12'd4, 11'd3, 11'd0, 12'd2, 12'd4, 6'd1);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'h8000, 1'b0);
        push_pixel(16'h0001, 1'b1);
        wait_drained();

        // Zero width and zero pitch: one pixel per row, samples but no gradients
        set_config(12'd0, 11'd0, 11'd1, 12'd5, 12'd3, 6'd0);
        push_pixel(16'h1234, 1'b0);
        push_pixel(16'hABCD, 1'b0);
        push_pixel(16'h5555, 1'b0);
        push_pixel(16'hAAAA, 1'b1);
        wait_drained();

        // Pitch changed in the middle of a frame
        set_config(12'd6, 11'd1, 11'd0, 12'd6, 12'd10, 6'd2);
        queue_pixels(5, 1'b0);
        wait_drained();
        write_reg(CFG_SAMPLE_STEP, 12'd3);
        queue_pixels(5, 1'b1);
        wait_drained();

        // Width above the maximum is clipped; right edge clipped to it
        set_config(12'hFFF, 11'd0, 11'd0, 12'hFFF, 12'd2, 6'd1);
        queue_pixels(24, 1'b1);
        wait_drained();

        // One pixel per row, region bottom far past the frame
        set_config(12'd0, 11'd0, 11'd3, 12'd1, 12'hFFF, 6'd2);
        queue_pixels(24, 1'b1);
        wait_drained();

        // Random phases, some leaving a frame open across the next writes
        random_pixels = 0;
        phase = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            calm = (phase == 3);
            randomize_config();
            repeat ($urandom_range(3, 8)) begin
                frame_len = $urandom_range(1, 48);
                queue_pixels(frame_len, 1'b1);
                random_pixels += frame_len;
            end
            if ($urandom_range(0, 2) == 0) begin
                frame_len = $urandom_range(1, 20);
                queue_pixels(frame_len, 1'b0);
                random_pixels += frame_len;
            end
            wait_drained();
            phase++;
        end
        calm = 1'b0;
        // Close a frame that may still be open
        queue_pixels(1, 1'b1);
        wait_drained();

        $display("Run covered %0d pixels, %0d frame reports and %0d register writes",
                 pixels_taken, frames_checked, cfg_writes);
        $display("over %0d random phases, with idling on both channels", phase);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("tb_region_luma_statistics_core OK");
        end else begin
            $display("tb_region_luma_statistics_core NOT OK");
        end
        $finish;
    end

    // Run limit
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("tb_region_luma_statistics_core NOT OK");
        $finish;
    end

endmodule
